@@ hdl/rwl_pkg.sv @@
// shared constants for the reader/writer lock arbiter
`default_nettype none
package rwl_pkg;

  // default widths
  localparam int ID_BITS_DEF    = 8;
  localparam int COUNT_BITS_DEF = 8;

  // fixed field widths
  localparam int OP_W      = 4;
  localparam int STATUS_W  = 2;
  localparam int READERS_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_READ        = 4'd0;
  localparam logic [OP_W-1:0] OP_WRITE       = 4'd1;
  localparam logic [OP_W-1:0] OP_DONE        = 4'd2;
  localparam logic [OP_W-1:0] OP_UPGRADE     = 4'd3;
  localparam logic [OP_W-1:0] OP_DOWNGRADE   = 4'd4;
  localparam logic [OP_W-1:0] OP_TRY_READ    = 4'd5;
  localparam logic [OP_W-1:0] OP_TRY_WRITE   = 4'd6;
  localparam logic [OP_W-1:0] OP_TRY_UPGRADE = 4'd7;
  localparam logic [OP_W-1:0] OP_SET_REC     = 4'd8;
  localparam logic [OP_W-1:0] OP_CLEAR_REC   = 4'd9;

  // status codes
  localparam logic [STATUS_W-1:0] ST_GRANT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DENY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCK = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERR   = 2'd3;

endpackage
`default_nettype wire

@@ hdl/reader_writer_lock_arbiter.sv @@
// reader/writer lock arbiter with upgrade, downgrade and recursive owner
// latency: a request beat accepted at one edge shows its result beat from the next cycle
// throughput: one request per cycle while the result side is not stalled; the lock state updates in the accepting cycle
// and the result register lets a new request in while the previous result is being taken
// reset (rst, synchronous): all lock state, may_sleep and the result valid are cleared
// config writes are always ready and take effect at the accepting edge
`default_nettype none
module reader_writer_lock_arbiter #(
  parameter int ID_BITS    = rwl_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = rwl_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rwl_pkg::OP_W-1:0]      operation,
  input  wire logic [ID_BITS-1:0]            requester_id,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rwl_pkg::STATUS_W-1:0]       status,
  output logic                               wake_waiters,
  output logic [rwl_pkg::READERS_W-1:0]      readers_held,
  output logic                               writer_held
);
  import rwl_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam int EXT_W = (COUNT_BITS > READERS_W) ? COUNT_BITS : READERS_W;

  // lock state
  logic                  may_sleep;
  logic [COUNT_BITS-1:0] reader_count, reader_count_next;
  logic                  write_wanted, write_wanted_next;
  logic                  upgrade_wanted, upgrade_wanted_next;
  logic [COUNT_BITS-1:0] nest_depth, nest_depth_next;
  logic [ID_BITS-1:0]    recursive_owner, recursive_owner_next;
  logic                  recursive_owner_valid, recursive_owner_valid_next;
  logic                  waiters_present, waiters_present_next;
  logic [ID_BITS-1:0]    pending_writer, pending_writer_next;
  logic                  pending_writer_valid, pending_writer_valid_next;
  logic [ID_BITS-1:0]    pending_upgrader, pending_upgrader_next;
  logic                  pending_upgrader_valid, pending_upgrader_valid_next;

  logic [STATUS_W-1:0]   st;
  logic                  wake;
  logic                  owner;
  logic                  released;
  logic                  is_try;
  logic                  accept;
  logic [EXT_W-1:0]      count_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign owner     = recursive_owner_valid && (recursive_owner == requester_id);

  // next lock state and result for the request on the inputs
  always_comb begin
    reader_count_next           = reader_count;
    write_wanted_next           = write_wanted;
    upgrade_wanted_next         = upgrade_wanted;
    nest_depth_next             = nest_depth;
    recursive_owner_next        = recursive_owner;
    recursive_owner_valid_next  = recursive_owner_valid;
    waiters_present_next        = waiters_present;
    pending_writer_next         = pending_writer;
    pending_writer_valid_next   = pending_writer_valid;
    pending_upgrader_next       = pending_upgrader;
    pending_upgrader_valid_next = pending_upgrader_valid;
    st       = ST_ERR;
    wake     = 1'b0;
    released = 1'b1;
    is_try   = (operation == OP_TRY_UPGRADE);
    case (operation)
      OP_READ, OP_TRY_READ: begin
        if (!owner && (write_wanted || upgrade_wanted)) begin
          if (operation == OP_READ) begin
            if (may_sleep) waiters_present_next = 1'b1;
            st = ST_BLOCK;
          end else begin
            st = ST_DENY;
          end
        end else if (reader_count == CNT_MAX) begin
          st = ST_ERR;
        end else begin
          reader_count_next = reader_count + CNT_ONE;
          st = ST_GRANT;
        end
      end
      OP_WRITE, OP_TRY_WRITE: begin
        if (owner) begin
          if (nest_depth == CNT_MAX) begin
            st = ST_ERR;
          end else begin
            nest_depth_next = nest_depth + CNT_ONE;
            st = ST_GRANT;
          end
        end else if (operation == OP_TRY_WRITE) begin
          if (write_wanted || upgrade_wanted || reader_count != '0) begin
            st = ST_DENY;
          end else begin
            write_wanted_next = 1'b1;
            st = ST_GRANT;
          end
        end else if (pending_writer_valid && pending_writer == requester_id) begin
          if (reader_count != '0 || upgrade_wanted) begin
            if (may_sleep) waiters_present_next = 1'b1;
            st = ST_BLOCK;
          end else begin
            pending_writer_valid_next = 1'b0;
            st = ST_GRANT;
          end
        end else if (write_wanted) begin
          if (may_sleep) waiters_present_next = 1'b1;
          st = ST_BLOCK;
        end else begin
          write_wanted_next = 1'b1;
          if (reader_count != '0 || upgrade_wanted) begin
            pending_writer_next       = requester_id;
            pending_writer_valid_next = 1'b1;
            if (may_sleep) waiters_present_next = 1'b1;
            st = ST_BLOCK;
          end else begin
            st = ST_GRANT;
          end
        end
      end
      OP_DONE: begin
        // release the innermost hold
        if (reader_count != '0) begin
          reader_count_next = reader_count - CNT_ONE;
        end else if (nest_depth != '0) begin
          nest_depth_next = nest_depth - CNT_ONE;
        end else if (upgrade_wanted) begin
          upgrade_wanted_next         = 1'b0;
          pending_upgrader_valid_next = 1'b0;
        end else if (write_wanted) begin
          write_wanted_next         = 1'b0;
          pending_writer_valid_next = 1'b0;
        end else begin
          released = 1'b0;
        end
        if (released) begin
          st = ST_GRANT;
          if (waiters_present && reader_count_next == '0) begin
            waiters_present_next = 1'b0;
            wake = 1'b1;
          end
        end
      end
      OP_UPGRADE, OP_TRY_UPGRADE: begin
        if (pending_upgrader_valid && pending_upgrader == requester_id) begin
          // retry of a recorded upgrader
          if (reader_count != '0) begin
            if (is_try || may_sleep) waiters_present_next = 1'b1;
            st = ST_BLOCK;
          end else begin
            pending_upgrader_valid_next = 1'b0;
            st = ST_GRANT;
          end
        end else if (reader_count == '0) begin
          st = ST_ERR;
        end else if (owner) begin
          if (nest_depth == CNT_MAX) begin
            st = ST_ERR;
          end else begin
            reader_count_next = reader_count - CNT_ONE;
            nest_depth_next   = nest_depth + CNT_ONE;
            st = ST_GRANT;
          end
        end else if (upgrade_wanted) begin
          // competing upgrade: the blocking form gives up its read
          st = ST_DENY;
          if (!is_try) begin
            reader_count_next = reader_count - CNT_ONE;
            if (waiters_present && reader_count_next == '0) begin
              waiters_present_next = 1'b0;
              wake = 1'b1;
            end
          end
        end else begin
          upgrade_wanted_next = 1'b1;
          reader_count_next   = reader_count - CNT_ONE;
          if (reader_count_next != '0) begin
            pending_upgrader_next       = requester_id;
            pending_upgrader_valid_next = 1'b1;
            if (is_try || may_sleep) waiters_present_next = 1'b1;
            st = ST_BLOCK;
          end else begin
            st = ST_GRANT;
          end
        end
      end
      OP_DOWNGRADE: begin
        if (reader_count != CNT_MAX) begin
          if (nest_depth != '0) begin
            nest_depth_next = nest_depth - CNT_ONE;
          end else if (upgrade_wanted) begin
            upgrade_wanted_next         = 1'b0;
            pending_upgrader_valid_next = 1'b0;
          end else if (write_wanted) begin
            write_wanted_next         = 1'b0;
            pending_writer_valid_next = 1'b0;
          end else begin
            released = 1'b0;
          end
          if (released) begin
            reader_count_next = reader_count + CNT_ONE;
            st = ST_GRANT;
            if (waiters_present) begin
              waiters_present_next = 1'b0;
              wake = 1'b1;
            end
          end
        end
      end
      OP_SET_REC: begin
        if (write_wanted) begin
          recursive_owner_next       = requester_id;
          recursive_owner_valid_next = 1'b1;
          st = ST_GRANT;
        end
      end
      OP_CLEAR_REC: begin
        if (owner) begin
          if (nest_depth == '0) recursive_owner_valid_next = 1'b0;
          st = ST_GRANT;
        end
      end
      default: begin
        st = ST_ERR;
      end
    endcase
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      may_sleep <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      may_sleep <= cfg_data;
    end
  end

  // lock state update on an accepted request beat
  always_ff @(posedge clk) begin
    if (rst) begin
      reader_count           <= '0;
      write_wanted           <= 1'b0;
      upgrade_wanted         <= 1'b0;
      nest_depth             <= '0;
      recursive_owner        <= '0;
      recursive_owner_valid  <= 1'b0;
      waiters_present        <= 1'b0;
      pending_writer         <= '0;
      pending_writer_valid   <= 1'b0;
      pending_upgrader       <= '0;
      pending_upgrader_valid <= 1'b0;
    end else if (accept) begin
      reader_count           <= reader_count_next;
      write_wanted           <= write_wanted_next;
      upgrade_wanted         <= upgrade_wanted_next;
      nest_depth             <= nest_depth_next;
      recursive_owner        <= recursive_owner_next;
      recursive_owner_valid  <= recursive_owner_valid_next;
      waiters_present        <= waiters_present_next;
      pending_writer         <= pending_writer_next;
      pending_writer_valid   <= pending_writer_valid_next;
      pending_upgrader       <= pending_upgrader_next;
      pending_upgrader_valid <= pending_upgrader_valid_next;
    end
  end

  assign count_ext = EXT_W'(reader_count_next);

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= st;
      wake_waiters <= wake;
      readers_held <= count_ext[READERS_W-1:0];
      writer_held  <= write_wanted_next || upgrade_wanted_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/rwl_checker.sv @@
// port-level checks for the reader/writer lock arbiter, bound to the top level
`default_nettype none
module rwl_checker #(
  parameter int ID_BITS    = rwl_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS = rwl_pkg::COUNT_BITS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic                          cfg_data,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [rwl_pkg::OP_W-1:0]      operation,
  input wire logic [ID_BITS-1:0]            requester_id,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rwl_pkg::STATUS_W-1:0]  status,
  input wire logic                          wake_waiters,
  input wire logic [rwl_pkg::READERS_W-1:0] readers_held,
  input wire logic                          writer_held
);
  import rwl_pkg::*;

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(wake_waiters)
      && $stable(readers_held) && $stable(writer_held))
    else $error("stalled result beat changed");

  // each accepted request gives a result beat next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // request side is open whenever the result register is free or draining
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow result register");

  // wakeup comes only with a grant or a denied upgrade
  a_wake: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_waiters |-> status == ST_GRANT || status == ST_DENY)
    else $error("wakeup with blocked or error status");

endmodule

bind reader_writer_lock_arbiter rwl_checker #(
  .ID_BITS(ID_BITS),
  .COUNT_BITS(COUNT_BITS)
) u_rwl_checker (.*);
`default_nettype wire

@@ test/reader_writer_lock_arbiter_tb.sv @@
// testbench for the reader/writer lock arbiter: directed and random requests, checked beat by beat
module reader_writer_lock_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwl_pkg::*;

  localparam int ID_BITS     = ID_BITS_DEF;
  localparam int COUNT_BITS  = COUNT_BITS_DEF;
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int STALL_LIMIT = 5000;
  localparam int SHOWN_ERRORS = 40;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [ID_BITS-1:0] id_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 wake;
    logic [READERS_W-1:0] readers;
    logic                 writer;
  } lock_result_t;

  // lock state tracker and queue of expected result beats
  class lock_scoreboard;
    bit                    sleep_on;
    logic [COUNT_BITS-1:0] readers;
    logic [COUNT_BITS-1:0] nest;
    bit                    wr;
    bit                    up;
    id_t                   rec_owner;
    bit                    rec_valid;
    bit                    waiters;
    id_t                   pend_writer;
    bit                    pw_valid;
    id_t                   pend_upgrader;
    bit                    pu_valid;
    lock_result_t          expected_q[$];
    int                    errors;
    int                    beats;

    function new();
      sleep_on = 0;
      readers = '0;
      nest = '0;
      wr = 0;
      up = 0;
      rec_owner = '0;
      rec_valid = 0;
      waiters = 0;
      pend_writer = '0;
      pw_valid = 0;
      pend_upgrader = '0;
      pu_valid = 0;
      errors = 0;
      beats = 0;
    endfunction

    function void set_may_sleep(logic value);
      sleep_on = value;
    endfunction

    function void mark_wait();
      if (sleep_on) waiters = 1;
    endfunction

    // upgrade and try upgrade, including the pending upgrader retry
    function logic [STATUS_W-1:0] take_upgrade(id_t id, bit is_try, bit owner);
      if (pu_valid && pend_upgrader == id) begin
        if (readers != 0) begin
          if (is_try || sleep_on) waiters = 1;
          return ST_BLOCK;
        end
        pu_valid = 0;
        return ST_GRANT;
      end
      if (readers == 0) return ST_ERR;
      if (owner) begin
        if (nest == COUNT_MAX) return ST_ERR;
        readers--;
        nest++;
        return ST_GRANT;
      end
      // someone else already upgrading
      if (up) begin
        if (!is_try) readers--;
        return ST_DENY;
      end
      up = 1;
      readers--;
      if (readers != 0) begin
        pend_upgrader = id;
        pu_valid = 1;
        if (is_try || sleep_on) waiters = 1;
        return ST_BLOCK;
      end
      return ST_GRANT;
    endfunction

    // accepted request beat: update lock state, queue the expected result
    function void note_request(op_t op, id_t id);
      bit                    owner;
      bit                    wake;
      logic [STATUS_W-1:0]   st;
      logic [COUNT_BITS-1:0] readers_was;
      lock_result_t          res;
      owner = rec_valid && rec_owner == id;
      st = ST_ERR;
      wake = 0;
      case (op)
        OP_READ, OP_TRY_READ: begin
          if (!owner && (wr || up)) begin
            if (op == OP_READ) begin
              mark_wait();
              st = ST_BLOCK;
            end else begin
              st = ST_DENY;
            end
          end else if (readers != COUNT_MAX) begin
            readers++;
            st = ST_GRANT;
          end
        end
        OP_WRITE, OP_TRY_WRITE: begin
          if (owner) begin
            if (nest != COUNT_MAX) begin
              nest++;
              st = ST_GRANT;
            end
          end else if (op == OP_TRY_WRITE) begin
            if (wr || up || readers != 0) begin
              st = ST_DENY;
            end else begin
              wr = 1;
              st = ST_GRANT;
            end
          end else if (pw_valid && pend_writer == id) begin
            if (readers != 0 || up) begin
              mark_wait();
              st = ST_BLOCK;
            end else begin
              pw_valid = 0;
              st = ST_GRANT;
            end
          end else if (wr) begin
            mark_wait();
            st = ST_BLOCK;
          end else begin
            wr = 1;
            if (readers != 0 || up) begin
              pend_writer = id;
              pw_valid = 1;
              mark_wait();
              st = ST_BLOCK;
            end else begin
              st = ST_GRANT;
            end
          end
        end
        OP_DONE: begin
          st = ST_GRANT;
          if (readers != 0) begin
            readers--;
          end else if (nest != 0) begin
            nest--;
          end else if (up) begin
            up = 0;
            pu_valid = 0;
          end else if (wr) begin
            wr = 0;
            pw_valid = 0;
          end else begin
            st = ST_ERR;
          end
          if (st == ST_GRANT && waiters && readers == 0) begin
            waiters = 0;
            wake = 1;
          end
        end
        OP_UPGRADE, OP_TRY_UPGRADE: begin
          readers_was = readers;
          st = take_upgrade(id, op == OP_TRY_UPGRADE, owner);
          // losing upgrade still dropped its read
          if (op == OP_UPGRADE && st == ST_DENY && readers_was != readers &&
              waiters && readers == 0) begin
            waiters = 0;
            wake = 1;
          end
        end
        OP_DOWNGRADE: begin
          if (readers != COUNT_MAX) begin
            st = ST_GRANT;
            if (nest != 0) begin
              nest--;
            end else if (up) begin
              up = 0;
              pu_valid = 0;
            end else if (wr) begin
              wr = 0;
              pw_valid = 0;
            end else begin
              st = ST_ERR;
            end
            if (st == ST_GRANT) begin
              readers++;
              if (waiters) begin
                waiters = 0;
                wake = 1;
              end
            end
          end
        end
        OP_SET_REC: begin
          if (wr) begin
            rec_owner = id;
            rec_valid = 1;
            st = ST_GRANT;
          end
        end
        OP_CLEAR_REC: begin
          if (owner) begin
            if (nest == 0) rec_valid = 0;
            st = ST_GRANT;
          end
        end
        default: begin
          st = ST_ERR;
        end
      endcase
      res.status = st;
      res.wake = wake;
      res.readers = readers;
      res.writer = wr || up;
      expected_q.push_back(res);
    endfunction

    task report(string field, int got, int want);
      errors++;
      if (errors <= SHOWN_ERRORS)
        $display("mismatch on %s at result beat %0d: got %0d, expected %0d",
                 field, beats, got, want);
    endtask

    // accepted result beat against the oldest expectation
    task check_result(logic [STATUS_W-1:0] st, logic wk, logic [READERS_W-1:0] rd, logic wh);
      lock_result_t want;
      beats++;
      if (expected_q.size() == 0) begin
        report("unexpected beat", 1, 0);
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status) report("status", st, want.status);
      if (wk !== want.wake) report("wake_waiters", wk, want.wake);
      if (rd !== want.readers) report("readers_held", rd, want.readers);
      if (wh !== want.writer) report("writer_held", wh, want.writer);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  op_t                  operation = '0;
  id_t                  requester_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic                 wake_waiters;
  logic [READERS_W-1:0] readers_held;
  logic                 writer_held;

  lock_scoreboard sb;
  int             idle_cycles = 0;
  int             hold_off_cycles = 0;
  int             burst_left = 0;

  reader_writer_lock_arbiter #(
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .requester_id (requester_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .wake_waiters (wake_waiters),
    .readers_held (readers_held),
    .writer_held  (writer_held)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_may_sleep(cfg_data);
      if (in_valid && in_ready) sb.note_request(operation, requester_id);
      if (out_valid && out_ready)
        sb.check_result(status, wake_waiters, readers_held, writer_held);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // no progress for too long
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // result side: stall patterns that change now and then, plus requested hold-offs
  initial begin : result_sink
    int mode;
    int span;
    int tick;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk);
        hold_off_cycles = 0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 80);
        end
        span--;
        tick++;
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = (tick % 4) != 3;
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // one request beat; called at a falling edge, returns at a falling edge
  task automatic offer(input op_t op, input id_t id);
    operation = op;
    requester_id = id;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // sender pause until every expected result beat is in
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_may_sleep(input logic value);
    wait_drained();
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // release everything held, then drop the recursive owner
  task automatic release_all();
    while (sb.readers != 0 || sb.nest != 0 || sb.wr || sb.up)
      offer(OP_DONE, id_t'($urandom));
    if (sb.rec_valid) offer(OP_CLEAR_REC, sb.rec_owner);
  endtask

  // next random request, steered by the current lock state
  function automatic void pick_request(output op_t op, output id_t id);
    int roll;
    roll = $urandom_range(0, 99);
    id = ($urandom_range(0, 3) == 0) ? id_t'($urandom) : id_t'($urandom_range(0, 5));
    if (roll < 5) begin
      op = op_t'($urandom_range(0, 15));
      id = id_t'($urandom);
    end else if (roll < 20 && sb.pw_valid) begin
      op = OP_WRITE;
      id = sb.pend_writer;
    end else if (roll < 32 && sb.pu_valid) begin
      op = $urandom_range(0, 1) ? OP_UPGRADE : OP_TRY_UPGRADE;
      id = sb.pend_upgrader;
    end else if (roll < 42 && sb.rec_valid) begin
      id = sb.rec_owner;
      case ($urandom_range(0, 5))
        0: op = OP_READ;
        1: op = OP_WRITE;
        2: op = OP_UPGRADE;
        3: op = OP_DONE;
        4: op = OP_CLEAR_REC;
        default: op = OP_TRY_UPGRADE;
      endcase
    end else if (roll < 46) begin
      op = OP_SET_REC;
    end else if (roll < 62) begin
      op = $urandom_range(0, 1) ? OP_READ : OP_TRY_READ;
    end else if (roll < 70) begin
      op = $urandom_range(0, 1) ? OP_WRITE : OP_TRY_WRITE;
    end else if (roll < 78) begin
      op = $urandom_range(0, 1) ? OP_UPGRADE : OP_TRY_UPGRADE;
    end else if (roll < 82) begin
      op = OP_DOWNGRADE;
    end else if (roll < 85) begin
      op = OP_CLEAR_REC;
    end else begin
      op = OP_DONE;
    end
  endfunction

  task automatic run_random(input int count);
    op_t op;
    id_t id;
    repeat (count) begin
      pick_request(op, id);
      offer(op, id);
    end
  endtask

  // reader count and owner nesting up to their limits and past them
  task automatic flood_limits();
    id_t owner_id;
    id_t other_id;
    owner_id = id_t'($urandom);
    other_id = owner_id + id_t'(1);
    release_all();
    while (sb.readers != COUNT_MAX) offer(OP_READ, id_t'($urandom));
    offer(OP_READ, other_id);
    offer(OP_DOWNGRADE, other_id);
    // writer left pending behind the full reader count becomes the owner
    offer(OP_WRITE, owner_id);
    offer(OP_SET_REC, owner_id);
    while (sb.nest != COUNT_MAX)
      offer($urandom_range(0, 1) ? OP_WRITE : OP_TRY_WRITE, owner_id);
    offer(OP_WRITE, owner_id);
    offer(OP_READ, owner_id);
    offer(OP_TRY_READ, other_id);
    offer(OP_UPGRADE, owner_id);
    offer(OP_DOWNGRADE, owner_id);
    offer(OP_TRY_UPGRADE, other_id);
  endtask

  // short hand-picked sequence through every operation and corner
  task automatic run_directed();
    // nothing held: underflow and misuse errors
    offer(OP_DONE, 8'd0);
    offer(OP_DOWNGRADE, 8'd1);
    offer(OP_UPGRADE, 8'd2);
    offer(OP_SET_REC, 8'd3);
    offer(OP_CLEAR_REC, 8'd3);
    offer(op_t'('1), 8'd4);
    // two readers, a writer left pending behind them
    offer(OP_READ, 8'd0);
    offer(OP_READ, 8'd255);
    offer(OP_TRY_WRITE, 8'd9);
    offer(OP_WRITE, 8'd7);
    offer(OP_READ, 8'd9);
    offer(OP_TRY_READ, 8'd9);
    // pending upgrader, competing upgrade, upgrader retry
    offer(OP_UPGRADE, 8'd0);
    offer(OP_UPGRADE, 8'd255);
    offer(OP_TRY_UPGRADE, 8'd0);
    offer(OP_WRITE, 8'd7);
    offer(OP_DOWNGRADE, 8'd0);
    offer(OP_DONE, 8'd0);
    offer(OP_WRITE, 8'd7);
    // recursive owner
    offer(OP_SET_REC, 8'd7);
    offer(OP_WRITE, 8'd7);
    offer(OP_READ, 8'd7);
    offer(OP_UPGRADE, 8'd7);
    offer(OP_CLEAR_REC, 8'd7);
    offer(OP_TRY_UPGRADE, 8'd7);
    offer(OP_DONE, 8'd7);
    offer(OP_DONE, 8'd7);
    offer(OP_DONE, 8'd7);
    offer(OP_CLEAR_REC, 8'd7);
  endtask

  // main sequence
  initial begin : stimulus
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_may_sleep(1'b1);
    run_directed();

    // long result hold-off while requests keep coming
    hold_off_cycles = 300;
    run_random(100);

    write_may_sleep(1'b0);
    run_random(70);

    write_may_sleep(1'b1);
    flood_limits();

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rwl_pkg.sv
hdl/reader_writer_lock_arbiter.sv
hdl/rwl_checker.sv
test/reader_writer_lock_arbiter_tb.sv
